// ----- sv/sha256_reduced_round_state_core_macros.svh -----
// assertion macros for the reduced-round sha-256 state core checker
// needs clk and rst visible in the scope that uses them
`ifndef SHA256_REDUCED_ROUND_STATE_CORE_MACROS_SVH
`define SHA256_REDUCED_ROUND_STATE_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SRRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SRRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sha256rrs_pkg.sv -----
// shared types and constants for the reduced-round sha-256 state core
// no dependencies
package sha256rrs_pkg;

  localparam int unsigned WORD_W         = 32;
  localparam int unsigned LANE_W         = 2 * WORD_W;
  localparam int unsigned RND_W          = 7;
  localparam int unsigned NUM_WORDS      = 8;
  localparam int unsigned K_DEPTH        = 64;
  localparam int unsigned K_IDX_W        = $clog2(K_DEPTH);
  localparam int unsigned MAX_ROUNDS_DEF = 64;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_t;

  typedef struct packed {
    logic [WORD_W-1:0] w_word;
    logic              apply_round;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane0;
    logic [LANE_W-1:0] lane1;
    logic [LANE_W-1:0] lane2;
    logic [LANE_W-1:0] lane3;
    logic [RND_W-1:0]  rounds_done;
  } result_t;

  // initial hash value, word a at index 0
  localparam words_t INIT_WORDS = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [WORD_W-1:0] ROUND_K [K_DEPTH] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

endpackage

// ----- sv/sha256_reduced_round_state_core.sv -----
// top level of the reduced-round sha-256 state core
// depends on sha256rrs_pkg
//
// Keeps the eight sha-256 working words a..h and a round counter. Each
// transaction on the item channel carries one schedule word Wt that is used
// as is (no message expansion), and may apply one compression round with the
// round constant picked by the counter; there is no feed-forward addition.
// A run ends on a transaction with last set, or on the one that applies
// round MAX_ROUNDS; the state is then sent on the result channel as four
// 64-bit lanes (lower-indexed word in the low half) with the round count,
// and the words return to the standard initial value. Throughput is one
// transaction per cycle while no result waits; result_valid rises once the
// item that closes the run has passed the input register and then the round
// logic into the state and result registers. The round recurrence closes
// through the working-word registers. While a result waits, the held item
// waits with it whether or not it closes a run, so the item channel stalls
// once the input register is also full.
module sha256_reduced_round_state_core
  import sha256rrs_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = MAX_ROUNDS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam logic [RND_W-1:0] LIMIT = RND_W'(MAX_ROUNDS);

  // input register stage
  logic             item_held;
  item_t            item_q;

  // working state
  words_t           words;
  logic [RND_W-1:0] round_index;

  // round datapath
  words_t           words_next;
  logic [RND_W-1:0] idx_inc;
  logic [RND_W-1:0] idx_after;
  logic             do_round;
  logic             emit;
  logic             advance;
  logic             fire;
  logic [WORD_W-1:0] sum0, sum1, choose, major, t1, t2;

  // the held item moves on when the result slot is free or being emptied
  assign advance    = !result_valid || result_ready;
  assign fire       = item_held && advance;
  assign item_ready = !item_held || advance;

  always_comb begin
    do_round  = item_q.apply_round && (round_index < LIMIT);
    idx_inc   = round_index + RND_W'(1);
    idx_after = do_round ? idx_inc : round_index;
    // a run closes on last, or when the round limit has just been reached
    emit      = item_q.last || (do_round && (idx_inc == LIMIT));

    sum1   = rotr(words[4], 6) ^ rotr(words[4], 11) ^ rotr(words[4], 25);
    choose = (words[4] & words[5]) ^ (~words[4] & words[6]);
    sum0   = rotr(words[0], 2) ^ rotr(words[0], 13) ^ rotr(words[0], 22);
    major  = (words[0] & words[1]) ^ (words[0] & words[2]) ^ (words[1] & words[2]);
    t1     = words[7] + sum1 + choose + ROUND_K[round_index[K_IDX_W-1:0]]
             + item_q.w_word;
    t2     = sum0 + major;

    words_next = words;
    if (do_round) begin
      words_next[7] = words[6];
      words_next[6] = words[5];
      words_next[5] = words[4];
      words_next[4] = words[3] + t1;
      words_next[3] = words[2];
      words_next[2] = words[1];
      words_next[1] = words[0];
      words_next[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_held    <= 1'b0;
      result_valid <= 1'b0;
      words        <= INIT_WORDS;
      round_index  <= '0;
    end else begin
      if (item_ready) begin
        item_held <= item_valid;
      end
      if (item_valid && item_ready) begin
        item_q <= item;
      end

      // a new result refills the slot in the same cycle it is emptied
      if (fire && emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (fire) begin
        if (emit) begin
          // pack the finished run and restart from the initial value
          result.lane0       <= {words_next[1], words_next[0]};
          result.lane1       <= {words_next[3], words_next[2]};
          result.lane2       <= {words_next[5], words_next[4]};
          result.lane3       <= {words_next[7], words_next[6]};
          result.rounds_done <= idx_after;
          words              <= INIT_WORDS;
          round_index        <= '0;
        end else begin
          words       <= words_next;
          round_index <= idx_after;
        end
      end
    end
  end

endmodule

// ----- sv/sha256rrs_checker.sv -----
// port-level checker for the reduced-round sha-256 state core, with its bind
// depends on sha256rrs_pkg and sha256_reduced_round_state_core_macros.svh
`include "sha256_reduced_round_state_core_macros.svh"

module sha256rrs_checker
  import sha256rrs_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = MAX_ROUNDS_DEF
) (
  input logic    clk,
  input logic    rst,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  logic result_stall;
  logic rounds_ok;
  logic zero_run;
  logic iv_lanes;

  assign result_stall = result_valid && !result_ready;
  assign rounds_ok    = result.rounds_done <= RND_W'(MAX_ROUNDS);
  assign zero_run     = result_valid && (result.rounds_done == '0);
  assign iv_lanes     = (result.lane0 == {INIT_WORDS[1], INIT_WORDS[0]}) &&
                        (result.lane1 == {INIT_WORDS[3], INIT_WORDS[2]}) &&
                        (result.lane2 == {INIT_WORDS[5], INIT_WORDS[4]}) &&
                        (result.lane3 == {INIT_WORDS[7], INIT_WORDS[6]});

  // a stalled result holds its transaction
  `SRRS_ASSERT_NEXT(a_result_hold, result_stall, result_valid && $stable(result), "result moved")

  // the round count never passes the limit
  `SRRS_ASSERT_NOW(a_rounds_limit, result_valid, rounds_ok, "rounds_done beyond limit")

  // a run with no rounds reports the initial value
  `SRRS_ASSERT_NOW(a_zero_run_iv, zero_run, iv_lanes, "zero-round run not at initial value")

  // with the result slot empty the item side never stalls
  `SRRS_ASSERT_NOW(a_no_idle_stall, !result_valid, item_ready, "item stall with empty slot")

endmodule

bind sha256_reduced_round_state_core sha256rrs_checker #(
  .MAX_ROUNDS(MAX_ROUNDS)
) u_sha256rrs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ----- bench/tb_sha256_reduced_round_state_core.sv -----
// self-checking bench for the reduced-round sha-256 state core
// depends on sha256rrs_pkg and sha256_reduced_round_state_core
// predicts each emitted state in-bench, compares lanes and round count per transaction
module tb_sha256_reduced_round_state_core;
  import sha256rrs_pkg::*;

  localparam int ROUND_LIMIT  = 64;
  localparam int TARGET_ITEMS = 1400;
  localparam int STALL_LIMIT  = 2000;

  // round constants and initial hash value, word a first
  localparam logic [31:0] RND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // dut ports, inputs given known values from time zero
  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // stimulus and scoreboard
  item_t   pending_items[$];
  result_t expected_states[$];
  result_t exp_state;
  logic [31:0] hash_words [8];
  logic [6:0]  round_count;
  int      total_items;
  int      sent_count   = 0;
  int      error_count  = 0;
  int      quiet_cycles = 0;
  int      phase;
  int      send_gap_pct;
  int      recv_stall_pct;

  sha256_reduced_round_state_core #(
    .MAX_ROUNDS(ROUND_LIMIT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // idling phases follow progress through the item stream:
  // none, sender gaps, receiver stalls, then both
  always_comb begin
    phase = (total_items == 0) ? 0 : (sent_count * 4) / total_items;
    case (phase)
      0: begin
        send_gap_pct = 0;   recv_stall_pct = 0;
      end
      1: begin
        send_gap_pct = 66;  recv_stall_pct = 0;
      end
      2: begin
        send_gap_pct = 0;   recv_stall_pct = 66;
      end
      default: begin
        send_gap_pct = 18;  recv_stall_pct = 18;
      end
    endcase
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_words[i] = IV_WORDS[i];
    round_count = '0;
  endtask

  // advance the predicted state by one accepted transaction
  task automatic track_round(input item_t it);
    logic [31:0] big_s1, choose, big_s0, major, t1, t2;
    logic        emit;
    result_t     r;
    emit = it.last;
    if (it.apply_round && round_count < ROUND_LIMIT) begin
      big_s1 = ror32(hash_words[4], 6) ^ ror32(hash_words[4], 11) ^
               ror32(hash_words[4], 25);
      choose = (hash_words[4] & hash_words[5]) ^ (~hash_words[4] & hash_words[6]);
      big_s0 = ror32(hash_words[0], 2) ^ ror32(hash_words[0], 13) ^
               ror32(hash_words[0], 22);
      major  = (hash_words[0] & hash_words[1]) ^ (hash_words[0] & hash_words[2]) ^
               (hash_words[1] & hash_words[2]);
      t1 = hash_words[7] + big_s1 + choose + RND_CONST[round_count[5:0]] + it.w_word;
      t2 = big_s0 + major;
      hash_words[7] = hash_words[6];
      hash_words[6] = hash_words[5];
      hash_words[5] = hash_words[4];
      hash_words[4] = hash_words[3] + t1;
      hash_words[3] = hash_words[2];
      hash_words[2] = hash_words[1];
      hash_words[1] = hash_words[0];
      hash_words[0] = t1 + t2;
      round_count = round_count + 7'd1;
      // round limit ends the run regardless of last
      if (round_count >= ROUND_LIMIT) emit = 1'b1;
    end
    if (emit) begin
      r.lane0       = {hash_words[1], hash_words[0]};
      r.lane1       = {hash_words[3], hash_words[2]};
      r.lane2       = {hash_words[5], hash_words[4]};
      r.lane3       = {hash_words[7], hash_words[6]};
      r.rounds_done = round_count;
      expected_states.push_back(r);
      restart_hash();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    error_count++;
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
  endtask

  task automatic add_item(input logic [31:0] w, input logic apply, input logic fin);
    item_t it;
    it.w_word      = w;
    it.apply_round = apply;
    it.last        = fin;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // one well-formed run; len of ROUND_LIMIT ends on the limit itself
  task automatic add_run(input int len, input int fin_on_limit);
    for (int i = 0; i < len; i++) begin
      // sprinkle idle transactions through the run
      if ($urandom_range(0, 19) == 0) add_item($urandom, 1'b0, 1'b0);
      if (i == len - 1 && len == ROUND_LIMIT) add_item(rand_word(), 1'b1, fin_on_limit != 0);
      else if (i == len - 1 && $urandom_range(0, 1) == 1) add_item(rand_word(), 1'b1, 1'b1);
      else add_item(rand_word(), 1'b1, 1'b0);
    end
    // runs shorter than the limit need an explicit end
    if (len < ROUND_LIMIT && (len == 0 || !pending_items[$].last))
      add_item($urandom, 1'b0, 1'b1);
  endtask

  // driver: the next item is loaded once the current transaction completes
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        track_round(item);
        sent_count <= sent_count + 1;
      end
      if (!item_valid || item_ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          item       <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (result_valid && result_ready) begin
        if (expected_states.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, result.lane0);
        end else begin
          exp_state = expected_states.pop_front();
          if (result.lane0 !== exp_state.lane0)
            report_mismatch("lane0", exp_state.lane0, result.lane0);
          if (result.lane1 !== exp_state.lane1)
            report_mismatch("lane1", exp_state.lane1, result.lane1);
          if (result.lane2 !== exp_state.lane2)
            report_mismatch("lane2", exp_state.lane2, result.lane2);
          if (result.lane3 !== exp_state.lane3)
            report_mismatch("lane3", exp_state.lane3, result.lane3);
          if (result.rounds_done !== exp_state.rounds_done)
            report_mismatch("rounds_done", 64'(exp_state.rounds_done),
                            64'(result.rounds_done));
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int real_items;
    restart_hash();

    // directed: zero-round run, idle transaction, word extremes
    add_item(32'h0000_0000, 1'b0, 1'b1);
    add_item(32'hffff_ffff, 1'b0, 1'b0);
    add_item(32'h0000_0000, 1'b1, 1'b0);
    add_item(32'hffff_ffff, 1'b1, 1'b0);
    add_item(32'h1234_5678, 1'b0, 1'b0);
    add_item(32'h8765_4321, 1'b0, 1'b1);
    // round and last together
    add_item(32'hffff_ffff, 1'b1, 1'b1);
    add_item(32'h0000_0000, 1'b1, 1'b1);
    add_item(32'ha5a5_a5a5, 1'b1, 1'b0);
    add_item(32'h5a5a_5a5a, 1'b1, 1'b1);
    // zero-round run right after another run
    add_item(32'hffff_ffff, 1'b0, 1'b1);
    add_item(32'h8000_0001, 1'b1, 1'b0);
    add_item(32'h7fff_fffe, 1'b1, 1'b0);
    add_item(32'h0000_0001, 1'b0, 1'b0);
    add_item(32'h8000_0000, 1'b0, 1'b1);

    // round limit hit with last low, then with last high
    add_run(ROUND_LIMIT, 0);
    add_run(ROUND_LIMIT, 1);

    // random runs, mostly short, some full length
    real_items = 0;
    foreach (pending_items[i])
      if (pending_items[i].apply_round || pending_items[i].last) real_items++;
    while (real_items < TARGET_ITEMS) begin
      int len, before_n;
      before_n = pending_items.size();
      case ($urandom_range(0, 9))
        0:       len = ROUND_LIMIT;
        1:       len = 0;
        2, 3, 4: len = $urandom_range(1, 8);
        default: len = $urandom_range(1, ROUND_LIMIT - 1);
      endcase
      add_run(len, $urandom_range(0, 1));
      for (int i = before_n; i < pending_items.size(); i++)
        if (pending_items[i].apply_round || pending_items[i].last) real_items++;
    end
    total_items = pending_items.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || item_valid) @(posedge clk);
    while (expected_states.size() != 0) @(posedge clk);
    // drain window after the expected results are all checked
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sha256_reduced_round_state_core.f -----
+incdir+sv
sv/sha256rrs_pkg.sv
sv/sha256_reduced_round_state_core.sv
sv/sha256rrs_checker.sv
bench/tb_sha256_reduced_round_state_core.sv
